[src/pls_pkg.sv]
// Shared types, request and status codes, and default sizes for the positional list store.
package pls_pkg;

    // Default sizes, used as parameter defaults on the top level.
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed port field widths.
    localparam int REQ_W    = 4;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Request codes carried on the request type port.
    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_FRONT    = 4'd0,
        REQ_ADD_END      = 4'd1,
        REQ_ADD_AT       = 4'd2,
        REQ_REMOVE_FRONT = 4'd3,
        REQ_REMOVE_END   = 4'd4,
        REQ_REMOVE_AT    = 4'd5,
        REQ_READ_FRONT   = 4'd6,
        REQ_READ_END     = 4'd7,
        REQ_READ_AT      = 4'd8,
        REQ_SEARCH       = 4'd9
    } t_req;

    // Status codes reported with every result.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Update that every cell of the row applies in parallel.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2
    } t_cell_op;

    // Control bundle broadcast from the decoder to the row of cells.
    typedef struct packed {
        t_cell_op op;
        logic     rd_en;
        logic     srch_en;
    } t_cell_ctl;

endpackage

[src/pls_cell.sv]
// One storage cell of the list row: holds one entry, shifts with its neighbors, reads and compares.
module pls_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IDX_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  pls_pkg::t_cell_ctl    i_ctl,
    input  logic [IDX_W-1:0]      i_target,
    input  logic [IDX_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_word,
    input  logic [DATA_WIDTH-1:0] i_prev_data,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    input  logic [DATA_WIDTH-1:0] i_rd_chain,
    input  logic                  i_hit_chain,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_rd_chain,
    output logic                  o_hit_chain
);
    import pls_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Insertion moves entries above the target up; removal pulls entries from above down.
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (MY_IDX == i_target) begin
                    n_data = i_word;
                end else if (MY_IDX > i_target) begin
                    n_data = i_prev_data;
                end
            end
            CELL_REMOVE: begin
                if (MY_IDX >= i_target) begin
                    n_data = i_next_data;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // The read word and the search hit ripple along the row, each cell adding its own share.
    assign o_rd_chain  = (i_ctl.rd_en && (MY_IDX == i_target)) ? r_data : i_rd_chain;
    assign o_hit_chain = i_hit_chain
                       | (i_ctl.srch_en && (MY_IDX < i_count) && (r_data == i_word));
    assign o_data      = r_data;

endmodule

[src/positional_list_store.sv]
// Top level of the positional list store: request decoder, row of cells and result register.
//
// The block keeps an ordered list of up to DEPTH words. It takes one request in every
// cycle (busy is never raised) and presents the result of each request for exactly one
// cycle on o_done, in the cycle after the request beat, in request order. All entries are
// updated in parallel by the row of cells at the accepting edge, so back-to-back inserts,
// removals, reads and searches need no spacing. The result register is the only latency.
// Entries hold no reset value; only the entry count and the result strobe are cleared, so
// the block is ready in the first cycle after reset with no clearing pass.
module positional_list_store #(
    parameter int DEPTH      = pls_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = pls_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [pls_pkg::REQ_W-1:0]     i_req_type,
    input  logic [pls_pkg::POS_W-1:0]     i_position,
    input  logic [pls_pkg::VALUE_W-1:0]   i_value,
    output logic                          o_done,
    output logic [pls_pkg::STATUS_W-1:0]  o_status,
    output logic [pls_pkg::VALUE_W-1:0]   o_read_data,
    output logic                          o_found,
    output logic [pls_pkg::COUNT_W-1:0]   o_entry_count
);
    import pls_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    logic                  accept;
    logic [DATA_WIDTH-1:0] word;
    logic [MW-1:0]         count_ext;
    logic [MW-1:0]         pos_ext;
    logic [MW-1:0]         target;
    t_cell_ctl             ctl;
    t_status               status;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_done;
    t_status               r_status;
    logic [VALUE_W-1:0]    r_read_data;
    logic                  r_found;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] rd_chain  [DEPTH+1];
    logic                  hit_chain [DEPTH+1];

    // The block never stalls a request.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign word      = DATA_WIDTH'(i_value);
    assign count_ext = MW'(r_count);
    assign pos_ext   = MW'(i_position);

    // Decode the request, check it against the count and pick the cell operation.
    always_comb begin
        ctl     = '{op: CELL_HOLD, rd_en: 1'b0, srch_en: 1'b0};
        target  = '0;
        status  = ST_OK;
        n_count = r_count;
        case (i_req_type)
            REQ_ADD_FRONT, REQ_ADD_END, REQ_ADD_AT: begin
                if (i_req_type == REQ_ADD_FRONT) begin
                    target = '0;
                end else if (i_req_type == REQ_ADD_END) begin
                    target = count_ext;
                end else begin
                    target = pos_ext;
                end
                if (r_count >= CW'(DEPTH)) begin
                    status = ST_FULL;
                end else if (target > count_ext) begin
                    status = ST_RANGE;
                end else begin
                    ctl.op  = CELL_INSERT;
                    n_count = r_count + CW'(1);
                end
            end
            REQ_REMOVE_FRONT, REQ_REMOVE_END, REQ_REMOVE_AT,
            REQ_READ_FRONT, REQ_READ_END, REQ_READ_AT: begin
                if ((i_req_type == REQ_REMOVE_FRONT) || (i_req_type == REQ_READ_FRONT)) begin
                    target = '0;
                end else if ((i_req_type == REQ_REMOVE_END) || (i_req_type == REQ_READ_END)) begin
                    target = count_ext - MW'(1);
                end else begin
                    target = pos_ext;
                end
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else if (target >= count_ext) begin
                    status = ST_RANGE;
                end else if ((i_req_type == REQ_REMOVE_FRONT) || (i_req_type == REQ_REMOVE_END)
                             || (i_req_type == REQ_REMOVE_AT)) begin
                    ctl.op  = CELL_REMOVE;
                    n_count = r_count - CW'(1);
                end else begin
                    ctl.rd_en = 1'b1;
                end
            end
            REQ_SEARCH: begin
                ctl.srch_en = 1'b1;
            end
            default: begin
                status = ST_OK;
            end
        endcase
        if (!accept) begin
            ctl     = '{op: CELL_HOLD, rd_en: 1'b0, srch_en: 1'b0};
            n_count = r_count;
        end
    end

    // Row of cells; data shifts between neighbors, read and search results ripple along.
    assign rd_chain[0]  = '0;
    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] prev_data;
        logic [DATA_WIDTH-1:0] next_data;

        if (g == 0) begin : g_first
            assign prev_data = '0;
        end else begin : g_inner_prev
            assign prev_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign next_data = '0;
        end else begin : g_inner_next
            assign next_data = cell_data[g+1];
        end

        pls_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX_W      (MW),
            .INDEX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_target    (target),
            .i_count     (count_ext),
            .i_word      (word),
            .i_prev_data (prev_data),
            .i_next_data (next_data),
            .i_rd_chain  (rd_chain[g]),
            .i_hit_chain (hit_chain[g]),
            .o_data      (cell_data[g]),
            .o_rd_chain  (rd_chain[g+1]),
            .o_hit_chain (hit_chain[g+1])
        );
    end

    // Entry count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    // Result payload, captured with each request beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_read_data <= VALUE_W'(rd_chain[DEPTH]);
            r_found     <= hit_chain[DEPTH];
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_read_data   = r_read_data;
    assign o_found       = r_found;
    assign o_entry_count = COUNT_W'(r_count);

endmodule
